FILE: design/sfss_pkg.sv
package sfss_pkg;

	localparam int MAX_TAPS = 32;
	localparam int PTR_W    = $clog2(MAX_TAPS);
	localparam int TAPS_W   = $clog2(MAX_TAPS + 1);
	localparam int CNT_W    = $clog2(MAX_TAPS + 2);
	localparam int ACC_W    = 32 + $clog2(MAX_TAPS) + 1;

	localparam int SMP_W    = 16;
	localparam int TCNT_W   = 6;
	localparam int SHIFT_W  = 5;
	localparam int IDX_W    = 5;
	localparam int CFG_W    = 6;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic CFG_TAP_COUNT    = 1'b0;
	localparam logic CFG_SHIFT_AMOUNT = 1'b1;

	localparam logic signed [SMP_W-1:0] SAT_MAX = 16'sd32767;
	localparam logic signed [SMP_W-1:0] SAT_MIN = -16'sd32768;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_OUT
	} seq_state_t;

	typedef struct packed {
		logic clear;
		logic acc_en;
	} mac_ctrl_t;

endpackage

FILE: design/sfss_store.sv
module sfss_store import sfss_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    coef_we,
	input  logic [PTR_W-1:0]        coef_widx,
	input  logic signed [SMP_W-1:0] coef_wval,
	input  logic                    smp_we,
	input  logic signed [SMP_W-1:0] smp_left,
	input  logic signed [SMP_W-1:0] smp_right,
	input  logic [PTR_W-1:0]        coef_ridx,
	input  logic [PTR_W-1:0]        smp_raddr,
	output logic [PTR_W-1:0]        wr_ptr,
	output logic signed [SMP_W-1:0] coef_rd,
	output logic signed [SMP_W-1:0] left_rd,
	output logic signed [SMP_W-1:0] right_rd
);

	logic signed [SMP_W-1:0] coef_q  [MAX_TAPS];
	logic signed [SMP_W-1:0] left_q  [MAX_TAPS];
	logic signed [SMP_W-1:0] right_q [MAX_TAPS];
	logic [MAX_TAPS-1:0]     coef_vld_q;
	logic [PTR_W-1:0]        wp_q;

	// valid bits stand in for the all-zero coefficient reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
			wp_q       <= '0;
		end else begin
			if (coef_we)
				coef_vld_q[coef_widx] <= 1'b1;
			if (smp_we)
				wp_q <= (wp_q == PTR_W'(MAX_TAPS - 1)) ? '0 : wp_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (coef_we)
			coef_q[coef_widx] <= coef_wval;
		if (smp_we) begin
			left_q[wp_q]  <= smp_left;
			right_q[wp_q] <= smp_right;
		end
	end

	assign wr_ptr   = wp_q;
	assign coef_rd  = coef_vld_q[coef_ridx] ? coef_q[coef_ridx] : '0;
	assign left_rd  = left_q[smp_raddr];
	assign right_rd = right_q[smp_raddr];

endmodule

FILE: design/sfss_mac.sv
module sfss_mac import sfss_pkg::*; (
	input  logic                    clk,
	input  mac_ctrl_t               ctrl,
	input  logic signed [SMP_W-1:0] coef,
	input  logic signed [SMP_W-1:0] left,
	input  logic signed [SMP_W-1:0] right,
	input  logic [SHIFT_W-1:0]      shift,
	output logic signed [SMP_W-1:0] sat_left,
	output logic signed [SMP_W-1:0] sat_right
);

	logic signed [ACC_W-1:0]   acc_l_q;
	logic signed [ACC_W-1:0]   acc_r_q;
	logic signed [2*SMP_W-1:0] prod_l;
	logic signed [2*SMP_W-1:0] prod_r;

	// shift magnitude toward zero, then clamp to 16 bits
	function automatic logic signed [SMP_W-1:0] scale_sat(
		input logic signed [ACC_W-1:0] acc,
		input logic [SHIFT_W-1:0]      sh
	);
		logic [ACC_W-1:0] mag;
		logic             neg;
		logic signed [SMP_W-1:0] r;
		neg = acc[ACC_W-1];
		mag = neg ? ACC_W'(-acc) : ACC_W'(acc);
		mag = mag >> sh;
		if (neg)
			r = (mag > ACC_W'(32768)) ? SAT_MIN : SMP_W'(-mag);
		else
			r = (mag > ACC_W'(32767)) ? SAT_MAX : SMP_W'(mag);
		return r;
	endfunction

	assign prod_l = left * coef;
	assign prod_r = right * coef;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			acc_l_q <= '0;
			acc_r_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_l_q <= acc_l_q + ACC_W'(prod_l);
			acc_r_q <= acc_r_q + ACC_W'(prod_r);
		end
	end

	assign sat_left  = scale_sat(acc_l_q, shift);
	assign sat_right = scale_sat(acc_r_q, shift);

endmodule

FILE: design/sfss_seq.sv
module sfss_seq import sfss_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               opcode,
	input  logic               block_start,
	input  logic [TCNT_W-1:0]  tap_count,
	input  logic               out_ready,
	input  logic [PTR_W-1:0]   wr_ptr,
	output logic               in_ready,
	output logic               out_valid,
	output logic               out_load,
	output mac_ctrl_t          mac_ctrl,
	output logic [PTR_W-1:0]   coef_ridx,
	output logic [PTR_W-1:0]   smp_raddr
);

	seq_state_t         state_q, state_d;
	logic [PTR_W-1:0]   step_q;
	logic [PTR_W-1:0]   addr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   cnt_d;
	logic               out_valid_q;
	logic [TAPS_W-1:0]  eff_taps;
	logic [PTR_W-1:0]   start_addr;
	logic               accept;
	logic               fire;
	logic               last;
	logic               out_free;
	int                 start_sum;

	always_comb begin
		if (tap_count == '0)
			eff_taps = TAPS_W'(1);
		else if (32'(tap_count) > MAX_TAPS)
			eff_taps = TAPS_W'(MAX_TAPS);
		else
			eff_taps = TAPS_W'(tap_count);
	end

	always_comb begin
		cnt_d = block_start ? '0 : cnt_q;
		if (32'(cnt_d) < MAX_TAPS + 1)
			cnt_d = cnt_d + 1'b1;
	end

	// oldest window sample: newest slot minus (taps - 1), wrapped
	always_comb begin
		start_sum = int'(wr_ptr) + MAX_TAPS - int'(eff_taps) + 1;
		if (start_sum >= MAX_TAPS)
			start_sum = start_sum - MAX_TAPS;
		start_addr = PTR_W'(start_sum);
	end

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign fire     = accept && (opcode == OP_SAMPLE) && (32'(cnt_d) > 32'(eff_taps));
	assign last     = (step_q == PTR_W'(eff_taps - 1'b1));
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (fire) state_d = ST_MAC;
			ST_MAC:  if (last) state_d = ST_OUT;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = (state_q == ST_IDLE);
		mac_ctrl.clear  = fire;
		mac_ctrl.acc_en = (state_q == ST_MAC);
		out_load        = (state_q == ST_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			addr_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && opcode == OP_SAMPLE)
				cnt_q <= cnt_d;
			if (fire) begin
				step_q <= '0;
				addr_q <= start_addr;
			end else if (state_q == ST_MAC) begin
				step_q <= step_q + 1'b1;
				addr_q <= (addr_q == PTR_W'(MAX_TAPS - 1)) ? '0 : addr_q + 1'b1;
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign coef_ridx = step_q;
	assign smp_raddr = addr_q;

endmodule

FILE: design/stereo_fir_shift_saturate.sv
// Channel | Signals                                                   | Handshake
// in      | opcode tap_index tap_value pcm_left pcm_right block_start | in_valid / in_ready
// out     | out_left out_right                                        | out_valid / out_ready
// cfg     | cfg_index cfg_data                                        | cfg_write, no wait
//
// Load item and sample item without result: no MAC pass; in_ready stays high.
// Sample item with result (taps = tap_count clamped to 1..32): clear, then one shared
// MAC pair stepping one tap per cycle, then output; in_ready is low until the result
// is registered. A result waits in the accumulators while the output register is full.
// The result stays in the output register while the next item is taken.
// No clearing pass after reset; coefficients read as zero until written.
module stereo_fir_shift_saturate import sfss_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    opcode,
	input  logic [IDX_W-1:0]        tap_index,
	input  logic signed [SMP_W-1:0] tap_value,
	input  logic signed [SMP_W-1:0] pcm_left,
	input  logic signed [SMP_W-1:0] pcm_right,
	input  logic                    block_start,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [SMP_W-1:0] out_left,
	output logic signed [SMP_W-1:0] out_right,
	input  logic                    cfg_write,
	input  logic                    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	logic [TCNT_W-1:0]       tap_count_q;
	logic [SHIFT_W-1:0]      shift_q;
	logic signed [SMP_W-1:0] out_left_q;
	logic signed [SMP_W-1:0] out_right_q;
	logic                    accept;
	logic                    coef_we;
	logic                    smp_we;
	logic                    out_load;
	mac_ctrl_t               mac_ctrl;
	logic [PTR_W-1:0]        wr_ptr;
	logic [PTR_W-1:0]        coef_ridx;
	logic [PTR_W-1:0]        smp_raddr;
	logic signed [SMP_W-1:0] coef_rd;
	logic signed [SMP_W-1:0] left_rd;
	logic signed [SMP_W-1:0] right_rd;
	logic signed [SMP_W-1:0] sat_left;
	logic signed [SMP_W-1:0] sat_right;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TCNT_W'(16);
			shift_q     <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_TAP_COUNT:    tap_count_q <= TCNT_W'(cfg_data);
				CFG_SHIFT_AMOUNT: shift_q     <= SHIFT_W'(cfg_data);
				default:          ;
			endcase
		end
	end

	assign accept  = in_valid && in_ready;
	assign coef_we = accept && (opcode == OP_LOAD) && (32'(tap_index) < MAX_TAPS);
	assign smp_we  = accept && (opcode == OP_SAMPLE);

	sfss_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef_we   (coef_we),
		.coef_widx (PTR_W'(tap_index)),
		.coef_wval (tap_value),
		.smp_we    (smp_we),
		.smp_left  (pcm_left),
		.smp_right (pcm_right),
		.coef_ridx (coef_ridx),
		.smp_raddr (smp_raddr),
		.wr_ptr    (wr_ptr),
		.coef_rd   (coef_rd),
		.left_rd   (left_rd),
		.right_rd  (right_rd)
	);

	sfss_mac u_mac (
		.clk       (clk),
		.ctrl      (mac_ctrl),
		.coef      (coef_rd),
		.left      (left_rd),
		.right     (right_rd),
		.shift     (shift_q),
		.sat_left  (sat_left),
		.sat_right (sat_right)
	);

	sfss_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.opcode      (opcode),
		.block_start (block_start),
		.tap_count   (tap_count_q),
		.out_ready   (out_ready),
		.wr_ptr      (wr_ptr),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.out_load    (out_load),
		.mac_ctrl    (mac_ctrl),
		.coef_ridx   (coef_ridx),
		.smp_raddr   (smp_raddr)
	);

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_left_q  <= sat_left;
			out_right_q <= sat_right;
		end
	end

	assign out_left  = out_left_q;
	assign out_right = out_right_q;

endmodule
